### src/ascrgb_pkg.sv
package ascrgb_pkg;

   // Line buffer geometry
   localparam int BUFFER_BYTES = 5;
   localparam int POS_W        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

   // Character codes
   localparam logic [7:0] CH_NUL     = 8'd0;
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_RED     = 8'd82;
   localparam logic [7:0] CH_GREEN   = 8'd71;
   localparam logic [7:0] CH_BLUE    = 8'd66;

   typedef logic [BUFFER_BYTES-1:0][7:0] line_type;

   // Number scan phases
   typedef enum logic [1:0] {
      SCAN_BLANK,
      SCAN_DIGITS,
      SCAN_DONE
   } scan_type;

endpackage

### src/ascrgb_decode.sv
module ascrgb_decode
   import ascrgb_pkg::*;
(
   input  line_type    line,
   output logic [15:0] value
);

   // Scan bytes 1 to the end: blanks, optional sign, then digits
   always_comb begin
      scan_type    phase;
      logic        neg;
      logic [15:0] acc;
      logic [7:0]  c;
      logic        is_digit;
      phase = SCAN_BLANK;
      neg   = 1'b0;
      acc   = 16'd0;
      for (int i = 1; i < BUFFER_BYTES; i++) begin
         c        = line[i];
         is_digit = c inside {[CH_ZERO:CH_NINE]};
         case (phase)
            SCAN_BLANK: begin
               if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
                  phase = SCAN_BLANK;
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  neg   = (c == CH_MINUS);
                  phase = SCAN_DIGITS;
               end else if (is_digit) begin
                  acc   = {12'd0, 4'(c - CH_ZERO)};
                  phase = SCAN_DIGITS;
               end else begin
                  phase = SCAN_DONE;
               end
            end
            SCAN_DIGITS: begin
               if (is_digit) begin
                  acc = (acc << 3) + (acc << 1) + {12'd0, 4'(c - CH_ZERO)};
               end else begin
                  phase = SCAN_DONE;
               end
            end
            default: phase = SCAN_DONE;
         endcase
      end
      value = neg ? 16'(16'd0 - acc) : acc;
   end

endmodule

### src/ascii_rgb_command_parser.sv
// ASCII RGB command parser. Bytes arrive on the req_ channel, one per
// transfer, at one byte per cycle while req_stall is low. A zero byte is
// dropped; any other byte except newline is stored in a five-byte line
// buffer that wraps. A newline decodes the line ("R", "G" or "B" followed
// by a decimal number, atoi style, truncated to 16 bits), updates that
// channel's level, and produces one rsp_ transfer carrying all three
// levels; the buffer is then cleared. The result is registered: a newline's
// levels enter the result register, or the skid register if an older result
// waits there untaken. The two entries keep input flowing while one waits;
// req_stall rises only when both hold results downstream has not yet taken.
module ascii_rgb_command_parser
   import ascrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_red_duty,
   output logic [15:0] rsp_green_duty,
   output logic [15:0] rsp_blue_duty
);

   line_type           line_ff, line_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        red_ff, red_in;
   logic [15:0]        green_ff, green_in;
   logic [15:0]        blue_ff, blue_in;
   logic               out_valid_ff, out_valid_in;
   logic [2:0][15:0]   out_ff, out_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [2:0][15:0]   skid_ff, skid_in;
   logic [15:0]        number;
   logic               accept;
   logic               newline;
   logic               take;

   ascrgb_decode u_decode (
      .line  (line_ff),
      .value (number)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign newline   = accept && (req_rx_char == CH_NEWLINE);
   assign take      = out_valid_ff && !rsp_stall;

   // Store bytes, apply commands on newline
   always_comb begin
      line_in  = line_ff;
      pos_in   = pos_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      if (newline) begin
         case (line_ff[0])
            CH_RED:   red_in   = number;
            CH_GREEN: green_in = number;
            CH_BLUE:  blue_in  = number;
            default:  ;
         endcase
         line_in = '0;
         pos_in  = '0;
      end else if (accept && req_rx_char != CH_NUL) begin
         line_in[pos_in] = req_rx_char;
         pos_in = (pos_ff == POS_W'(BUFFER_BYTES - 1)) ? '0 : POS_W'(pos_ff + 1'b1);
      end
   end

   // Route results through the result and skid registers
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (newline) begin
         if (!out_valid_ff || take) begin
            out_in       = {blue_in, green_in, red_in};
            out_valid_in = 1'b1;
         end else begin
            skid_in       = {blue_in, green_in, red_in};
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and level registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff       <= '0;
         pos_ff        <= '0;
         red_ff        <= 16'd0;
         green_ff      <= 16'd0;
         blue_ff       <= 16'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         line_ff       <= line_in;
         pos_ff        <= pos_in;
         red_ff        <= red_in;
         green_ff      <= green_in;
         blue_ff       <= blue_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red_duty   = out_ff[0];
   assign rsp_green_duty = out_ff[1];
   assign rsp_blue_duty  = out_ff[2];

   // Skid entry only ever backs up a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while result register is empty");

   // After every newline transfer, rsp_valid is high in the next cycle
   a_newline_result: assert property (@(posedge clock) disable iff (reset)
      newline |=> rsp_valid)
      else $error("newline transfer produced no result");

   // Newline clears the write position
   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      newline |=> (pos_ff == '0))
      else $error("write position not cleared after newline");

   // Write position stays inside the buffer
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(BUFFER_BYTES - 1))
      else $error("write position beyond buffer");

endmodule

### tb/ascii_rgb_duty_checker.sv
// Watches both channels of the RGB command parser. Each accepted nonzero byte
// advances a private copy of the line buffer and the three duty levels; each
// newline queues the duty set that the parser must return, and each accepted
// result is compared against the oldest queued set.
module ascii_rgb_duty_checker
   import ascrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_char,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_red_duty,
   input  logic [15:0] rsp_green_duty,
   input  logic [15:0] rsp_blue_duty,
   output int          mismatch_count,
   output int          outstanding,
   output int          duty_checked
);

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } duty_set_type;

   duty_set_type duty_expect_q[$];
   duty_set_type oldest_set;
   duty_set_type next_set;
   line_type    line_bytes;
   int unsigned fill_pos;
   logic [15:0] red_level;
   logic [15:0] green_level;
   logic [15:0] blue_level;
   logic [15:0] line_value;
   int          errors;
   int          checked;

   function automatic bit is_blank_char(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Decode the number in bytes 1 and up: blanks, one sign, then digits,
   // stopping at the first non-digit or at the end of the line buffer.
   function automatic logic [15:0] decode_line_number(input line_type text);
      int          idx;
      logic [15:0] acc;
      bit          negative;
      idx      = 1;
      acc      = 16'd0;
      negative = 1'b0;
      while (idx < BUFFER_BYTES && is_blank_char(text[idx]))
         idx++;
      if (idx < BUFFER_BYTES && (text[idx] == CH_PLUS || text[idx] == CH_MINUS)) begin
         negative = (text[idx] == CH_MINUS);
         idx++;
      end
      while (idx < BUFFER_BYTES && text[idx] >= CH_ZERO && text[idx] <= CH_NINE) begin
         acc = acc * 16'd10 + 16'(text[idx] - CH_ZERO);
         idx++;
      end
      if (negative)
         acc = 16'd0 - acc;
      return acc;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         if (errors < 10)
            $display("mismatch on %s duty: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         duty_expect_q.delete();
         line_bytes  = '0;
         fill_pos    = 0;
         red_level   = 16'd0;
         green_level = 16'd0;
         blue_level  = 16'd0;
      end else begin
         // Advance the line model on each byte transfer; zero bytes carry nothing
         if (req_valid && !req_stall && req_rx_char != CH_NUL) begin
            if (req_rx_char == CH_NEWLINE) begin
               line_value = decode_line_number(line_bytes);
               case (line_bytes[0])
                  CH_RED:   red_level   = line_value;
                  CH_GREEN: green_level = line_value;
                  CH_BLUE:  blue_level  = line_value;
                  default:  ;
               endcase
               next_set.red   = red_level;
               next_set.green = green_level;
               next_set.blue  = blue_level;
               duty_expect_q.push_back(next_set);
               line_bytes = '0;
               fill_pos   = 0;
            end else begin
               line_bytes[fill_pos] = req_rx_char;
               fill_pos = (fill_pos + 1) % BUFFER_BYTES;
            end
         end

         // Compare each result transfer with the oldest queued duty set
         if (rsp_valid && !rsp_stall) begin
            if (duty_expect_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result: red %0d green %0d blue %0d",
                           rsp_red_duty, rsp_green_duty, rsp_blue_duty);
               errors++;
            end else begin
               oldest_set = duty_expect_q.pop_front();
               compare_field("red", oldest_set.red, rsp_red_duty);
               compare_field("green", oldest_set.green, rsp_green_duty);
               compare_field("blue", oldest_set.blue, rsp_blue_duty);
               checked++;
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= duty_expect_q.size();
      duty_checked   <= checked;
   end

endmodule

### tb/ascii_rgb_command_parser_tb.sv
module ascii_rgb_command_parser_tb;
   import ascrgb_pkg::*;

   localparam int RUN_LIMIT   = 400000;
   localparam int RANDOM_BYTES = 800;

   typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_SPARSE} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_char = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_red_duty;
   logic [15:0] rsp_green_duty;
   logic [15:0] rsp_blue_duty;

   int          mismatch_count;
   int          outstanding;
   int          duty_checked;
   int          bytes_sent = 0;
   int          zeros_sent = 0;
   int          burst_left = 0;
   bit          paused_midway = 1'b0;

   stall_mode_type stall_mode = STALL_NONE;
   int          stall_left = 0;
   int          stall_tick = 0;

   ascii_rgb_command_parser uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_duty   (rsp_red_duty),
      .rsp_green_duty (rsp_green_duty),
      .rsp_blue_duty  (rsp_blue_duty)
   );

   ascii_rgb_duty_checker duty_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_duty   (rsp_red_duty),
      .rsp_green_duty (rsp_green_duty),
      .rsp_blue_duty  (rsp_blue_duty),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .duty_checked   (duty_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side in phases: none, coin flip, long runs, rare
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 120);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_COIN:   rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_LONG:   rsp_stall <= ((stall_tick % 16) < 11);
         default:      rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Offer one byte and hold it until the transfer; idle between bursts
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_rx_char <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      burst_left--;
      if (value == CH_NUL)
         zeros_sent++;
      else
         bytes_sent++;
   endtask

   // Now and then slip an idle zero byte in front of a character
   task automatic send_char(input logic [7:0] value);
      if ($urandom_range(0, 9) == 0)
         send_byte(CH_NUL);
      send_byte(value);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i]);
   endtask

   // Hold the sender until every queued duty set has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] random_symbol();
      logic [7:0] value;
      do
         value = 8'($urandom_range(1, 255));
      while (value == CH_NEWLINE);
      return value;
   endfunction

   // Command line: letter, optional blanks and sign, digits, newline
   task automatic send_command_line();
      int         pick;
      int         count;
      logic [7:0] letter;
      pick = $urandom_range(0, 9);
      if (pick < 3)
         letter = CH_RED;
      else if (pick < 6)
         letter = CH_GREEN;
      else if (pick < 9)
         letter = CH_BLUE;
      else
         letter = random_symbol();
      send_char(letter);
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (count) begin
         if ($urandom_range(0, 2) == 0)
            send_char(CH_SPACE);
         else
            send_char(8'(CH_TAB + $urandom_range(0, 4)));
      end
      pick = $urandom_range(0, 3);
      if (pick == 1)
         send_char(CH_PLUS);
      else if (pick == 2)
         send_char(CH_MINUS);
      count = $urandom_range(0, 4);
      repeat (count)
         send_char(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 5) == 0)
         send_char(random_symbol());
      send_char(CH_NEWLINE);
   endtask

   // Junk line of arbitrary bytes, long enough at times to wrap the buffer
   task automatic send_noise_line();
      int count;
      count = $urandom_range(0, 9);
      repeat (count)
         send_char(random_symbol());
      send_byte(CH_NEWLINE);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: widest number, dropped zero byte, negative wrap, blank and
      // plus sign, unknown command letter, buffer overrun
      send_text("R9999\n");
      send_byte(CH_NUL);
      send_text("G-12\n");
      send_text("B\t+7\n");
      send_byte(8'hFF);
      send_text("5\n");
      send_text("B12345\n");
      wait_drained();

      // Random: mostly command lines, the rest junk
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 4) != 0)
            send_command_line();
         else
            send_noise_line();
         if (!paused_midway && bytes_sent > RANDOM_BYTES / 2) begin
            paused_midway = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);

      $display("covered %0d bytes plus %0d idle zero bytes, %0d duty sets compared",
               bytes_sent, zeros_sent, duty_checked);
      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #RUN_LIMIT;
      $display("timeout with %0d duty sets outstanding", outstanding);
      $display("status: fail");
      $finish;
   end

endmodule
